// ----- src/sacts_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sacts_pkg
// Shared types, constants and helper functions of the cache tag store.
// ----------------------------------------------------------------------------
package sacts_pkg;

  localparam int WAYS_DEF     = 8;
  localparam int NUM_SETS_DEF = 256;

  localparam int TAG_W     = 32;
  localparam int TIME_W    = 64;
  localparam int CNT_W     = 32;
  localparam int WAY_OUT_W = 3;
  localparam int MAX_WAY_W = 4;
  localparam int CFG_W     = 4;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  localparam logic [CFG_W-1:0] SET_LOG2_RST = 4'd8;

  localparam logic CFG_SET_LOG2 = 1'b0;
  localparam logic CFG_POLICY   = 1'b1;

  localparam logic POLICY_LRU  = 1'b0;
  localparam logic POLICY_RAND = 1'b1;

  localparam logic OP_LOOKUP  = 1'b0;
  localparam logic OP_INSTALL = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic                 hit;
    logic [MAX_WAY_W-1:0] hit_way;
    logic                 inv;
    logic [MAX_WAY_W-1:0] inv_way;
    logic [MAX_WAY_W-1:0] lru_way;
  } scan_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_MOD,
    ST_FETCH,
    ST_UPD,
    ST_OUT
  } state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
  endfunction

  function automatic logic [15:0] lfsr_next(input logic [15:0] v);
    lfsr_next = {v[0] ^ v[2] ^ v[3] ^ v[5], v[15:1]};
  endfunction

endpackage
`default_nettype wire

// ----- src/sacts_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sacts_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sacts_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [(D>1?$clog2(D):1)-1:0] waddr,
  input  wire logic [W-1:0]                 wdata,
  input  wire logic [(D>1?$clog2(D):1)-1:0] raddr,
  output logic      [W-1:0]                 rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- src/sacts_scan.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sacts_scan
// Per-way compare unit: one way a cycle while vld is set; tracks first hit,
// first invalid way and the last way holding the minimum timestamp.
// ----------------------------------------------------------------------------
module sacts_scan #(
  parameter int WAYS = sacts_pkg::WAYS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              vld,
  input  wire logic [(WAYS>1?$clog2(WAYS):1)-1:0] way,
  input  wire sacts_pkg::entry_t                 ent,
  input  wire logic [sacts_pkg::TAG_W-1:0]       tag,
  output sacts_pkg::scan_res_t                   res
);

  logic [sacts_pkg::TIME_W-1:0]    lru_time_r;
  logic [sacts_pkg::MAX_WAY_W-1:0] way_x;
  logic                            match;
  logic                            first;

  assign way_x = sacts_pkg::MAX_WAY_W'(way);
  assign match = ent.valid && (ent.tag == tag);
  assign first = (way_x == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res.hit <= 1'b0;
      res.inv <= 1'b0;
    end else if (vld) begin
      if (first || (!res.hit && match)) begin
        res.hit     <= match;
        res.hit_way <= way_x;
      end
      if (first || (!res.inv && !ent.valid)) begin
        res.inv     <= !ent.valid;
        res.inv_way <= way_x;
      end
      if (first || (ent.stamp <= lru_time_r)) begin
        res.lru_way <= way_x;
        lru_time_r  <= ent.stamp;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/set_assoc_cache_tag_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_store
// Tag store of a set-associative cache with LRU or pseudo-random victims.
// Flow: SCAN reads one way of the set per cycle through the single tag RAM
//   read port; DECIDE picks the hit or victim way (MOD draws a random one);
//   FETCH reads that entry (not on a lookup miss), then UPD and OUT.
// Throughput: one request at a time; ready again the cycle after the result
//   is taken.
// Reset: clears counters and LFSR, then sweeps the tag RAM one entry a
//   cycle, (2^floor(log2 NUM_SETS))*WAYS entries, before the first request.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_store #(
  parameter int WAYS     = sacts_pkg::WAYS_DEF,
  parameter int NUM_SETS = sacts_pkg::NUM_SETS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic                                 cfg_index,
  input  wire logic [sacts_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 in_op,
  input  wire logic [31:0]                          in_line_addr,
  input  wire logic                                 in_is_write,
  input  wire logic [63:0]                          in_now_time,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_hit,
  output logic [sacts_pkg::WAY_OUT_W-1:0]           out_victim_way,
  output logic                                      out_evicted_valid,
  output logic                                      out_evicted_dirty,
  output logic [31:0]                               out_evicted_tag,
  output logic [31:0]                               out_read_accesses,
  output logic [31:0]                               out_write_accesses,
  output logic [31:0]                               out_read_misses,
  output logic [31:0]                               out_write_misses,
  output logic [31:0]                               out_dirty_evictions
);

  localparam int KMAX  = $clog2(NUM_SETS + 1) - 1;
  localparam int SW    = (KMAX > 0) ? KMAX : 1;
  localparam int LINES = (1 << KMAX) * WAYS;
  localparam int AW    = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int IW    = $clog2(WAYS + 1);
  localparam int CW    = sacts_pkg::CNT_W;

  localparam int                RECIP_SH = 20;
  localparam logic [RECIP_SH:0] RECIP    = (RECIP_SH + 1)'((1 << RECIP_SH) / WAYS + 1);

  sacts_pkg::state_t state_r, state_nxt;

  logic [sacts_pkg::CFG_W-1:0] log2_r;
  logic                        policy_r;

  logic [AW-1:0]  clr_r, clr_nxt;
  logic [AW-1:0]  base_r, base_nxt;
  logic [31:0]    tag_r, tag_nxt;
  logic [63:0]    now_r, now_nxt;
  logic           op_r, op_nxt;
  logic           wr_r, wr_nxt;
  logic [IW-1:0]  iss_r, iss_nxt;
  logic           rd_vld_r, rd_vld_nxt;
  logic [WW-1:0]  rd_way_r, rd_way_nxt;
  logic [WW-1:0]  way_r, way_nxt;
  logic [15:0]    lfsr_r, lfsr_nxt;

  logic [CW-1:0] rd_acc_r, rd_acc_nxt;
  logic [CW-1:0] wr_acc_r, wr_acc_nxt;
  logic [CW-1:0] rd_mis_r, rd_mis_nxt;
  logic [CW-1:0] wr_mis_r, wr_mis_nxt;
  logic [CW-1:0] dev_r, dev_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic                            o_hit_r, o_hit_nxt;
  logic [sacts_pkg::WAY_OUT_W-1:0] o_way_r, o_way_nxt;
  logic                            o_evv_r, o_evv_nxt;
  logic                            o_evd_r, o_evd_nxt;
  logic [31:0]                     o_evt_r, o_evt_nxt;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  sacts_pkg::entry_t           ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [sacts_pkg::ENTRY_W-1:0] ram_rdata;
  sacts_pkg::entry_t           rd_ent;
  sacts_pkg::scan_res_t        scan_res;

  logic [4:0]    k_cfg;
  logic [4:0]    k_eff;
  logic [SW:0]   one_sh;
  logic [SW-1:0] set_w;
  logic [35:0]   rnd_prod;
  logic [15:0]   rnd_quo;
  logic [15:0]   rnd_rem;
  logic          accept;

  assign rd_ent = sacts_pkg::entry_t'(ram_rdata);
  assign accept = in_valid && in_ready;

  assign k_cfg  = {1'b0, log2_r};
  assign k_eff  = (k_cfg > 5'(KMAX)) ? 5'(KMAX) : k_cfg;
  assign one_sh = (SW + 1)'(1) << k_eff;
  assign set_w  = in_line_addr[SW-1:0] & SW'(one_sh - (SW + 1)'(1));

  assign rnd_prod = 36'(lfsr_r) * 36'(RECIP);
  assign rnd_quo  = 16'(rnd_prod >> RECIP_SH);
  assign rnd_rem  = lfsr_r - rnd_quo * 16'(WAYS);

  sacts_ram #(
    .W (sacts_pkg::ENTRY_W),
    .D (LINES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sacts_scan #(
    .WAYS (WAYS)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .vld   (rd_vld_r),
    .way   (rd_way_r),
    .ent   (rd_ent),
    .tag   (tag_r),
    .res   (scan_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_r   <= sacts_pkg::SET_LOG2_RST;
      policy_r <= sacts_pkg::POLICY_LRU;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sacts_pkg::CFG_SET_LOG2: log2_r   <= cfg_wdata;
        sacts_pkg::CFG_POLICY:   policy_r <= cfg_wdata[0];
        default:                 log2_r   <= log2_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sacts_pkg::ST_CLEAR;
      clr_r       <= '0;
      rd_vld_r    <= 1'b0;
      lfsr_r      <= sacts_pkg::LFSR_SEED;
      rd_acc_r    <= '0;
      wr_acc_r    <= '0;
      rd_mis_r    <= '0;
      wr_mis_r    <= '0;
      dev_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      lfsr_r      <= lfsr_nxt;
      rd_acc_r    <= rd_acc_nxt;
      wr_acc_r    <= wr_acc_nxt;
      rd_mis_r    <= rd_mis_nxt;
      wr_mis_r    <= wr_mis_nxt;
      dev_r       <= dev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r   <= base_nxt;
    tag_r    <= tag_nxt;
    now_r    <= now_nxt;
    op_r     <= op_nxt;
    wr_r     <= wr_nxt;
    iss_r    <= iss_nxt;
    rd_way_r <= rd_way_nxt;
    way_r    <= way_nxt;
    o_hit_r  <= o_hit_nxt;
    o_way_r  <= o_way_nxt;
    o_evv_r  <= o_evv_nxt;
    o_evd_r  <= o_evd_nxt;
    o_evt_r  <= o_evt_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    base_nxt      = base_r;
    tag_nxt       = tag_r;
    now_nxt       = now_r;
    op_nxt        = op_r;
    wr_nxt        = wr_r;
    iss_nxt       = iss_r;
    rd_vld_nxt    = 1'b0;
    rd_way_nxt    = rd_way_r;
    way_nxt       = way_r;
    lfsr_nxt      = lfsr_r;
    rd_acc_nxt    = rd_acc_r;
    wr_acc_nxt    = wr_acc_r;
    rd_mis_nxt    = rd_mis_r;
    wr_mis_nxt    = wr_mis_r;
    dev_nxt       = dev_r;
    out_valid_nxt = out_valid_r;
    o_hit_nxt     = o_hit_r;
    o_way_nxt     = o_way_r;
    o_evv_nxt     = o_evv_r;
    o_evd_nxt     = o_evd_r;
    o_evt_nxt     = o_evt_r;
    ram_we        = 1'b0;
    ram_waddr     = base_r + AW'(way_r);
    ram_wdata     = '0;
    ram_raddr     = base_r + AW'(way_r);
    in_ready      = 1'b0;

    unique case (state_r)
      sacts_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(LINES - 1)) begin
          state_nxt = sacts_pkg::ST_IDLE;
        end
      end
      sacts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          base_nxt  = AW'(set_w) * AW'(WAYS);
          tag_nxt   = in_line_addr >> k_eff;
          now_nxt   = in_now_time;
          op_nxt    = in_op;
          wr_nxt    = in_is_write;
          iss_nxt   = '0;
          state_nxt = sacts_pkg::ST_SCAN;
        end
      end
      sacts_pkg::ST_SCAN: begin
        if (iss_r != IW'(WAYS)) begin
          ram_raddr  = base_r + AW'(iss_r);
          iss_nxt    = iss_r + IW'(1);
          rd_vld_nxt = 1'b1;
          rd_way_nxt = WW'(iss_r);
        end
        if (rd_vld_r && (rd_way_r == WW'(WAYS - 1))) begin
          state_nxt = sacts_pkg::ST_DECIDE;
        end
      end
      sacts_pkg::ST_DECIDE: begin
        if (op_r == sacts_pkg::OP_LOOKUP) begin
          way_nxt   = scan_res.hit ? WW'(scan_res.hit_way) : '0;
          state_nxt = scan_res.hit ? sacts_pkg::ST_FETCH : sacts_pkg::ST_UPD;
        end else if (scan_res.inv) begin
          way_nxt   = WW'(scan_res.inv_way);
          state_nxt = sacts_pkg::ST_FETCH;
        end else if (policy_r == sacts_pkg::POLICY_LRU) begin
          way_nxt   = WW'(scan_res.lru_way);
          state_nxt = sacts_pkg::ST_FETCH;
        end else begin
          lfsr_nxt  = sacts_pkg::lfsr_next(lfsr_r);
          state_nxt = sacts_pkg::ST_MOD;
        end
      end
      sacts_pkg::ST_MOD: begin
        way_nxt   = WW'(rnd_rem);
        state_nxt = sacts_pkg::ST_FETCH;
      end
      sacts_pkg::ST_FETCH: begin
        state_nxt = sacts_pkg::ST_UPD;
      end
      sacts_pkg::ST_UPD: begin
        o_way_nxt = sacts_pkg::WAY_OUT_W'(way_r);
        if (op_r == sacts_pkg::OP_LOOKUP) begin
          o_hit_nxt = scan_res.hit;
          o_evv_nxt = 1'b0;
          o_evd_nxt = 1'b0;
          o_evt_nxt = '0;
          if (wr_r) begin
            wr_acc_nxt = sacts_pkg::sat_inc(wr_acc_r);
          end else begin
            rd_acc_nxt = sacts_pkg::sat_inc(rd_acc_r);
          end
          if (scan_res.hit) begin
            ram_we          = 1'b1;
            ram_wdata.valid = 1'b1;
            ram_wdata.dirty = rd_ent.dirty | wr_r;
            ram_wdata.tag   = rd_ent.tag;
            ram_wdata.stamp = now_r;
          end else if (wr_r) begin
            wr_mis_nxt = sacts_pkg::sat_inc(wr_mis_r);
          end else begin
            rd_mis_nxt = sacts_pkg::sat_inc(rd_mis_r);
          end
        end else begin
          o_hit_nxt       = 1'b0;
          o_evv_nxt       = rd_ent.valid;
          o_evd_nxt       = rd_ent.valid & rd_ent.dirty;
          o_evt_nxt       = rd_ent.valid ? rd_ent.tag : '0;
          if (rd_ent.valid && rd_ent.dirty) begin
            dev_nxt = sacts_pkg::sat_inc(dev_r);
          end
          ram_we          = 1'b1;
          ram_wdata.valid = 1'b1;
          ram_wdata.dirty = wr_r;
          ram_wdata.tag   = tag_r;
          ram_wdata.stamp = now_r;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = sacts_pkg::ST_OUT;
      end
      sacts_pkg::ST_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = sacts_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sacts_pkg::ST_IDLE;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = o_hit_r;
  assign out_victim_way      = o_way_r;
  assign out_evicted_valid   = o_evv_r;
  assign out_evicted_dirty   = o_evd_r;
  assign out_evicted_tag     = o_evt_r;
  assign out_read_accesses   = rd_acc_r;
  assign out_write_accesses  = wr_acc_r;
  assign out_read_misses     = rd_mis_r;
  assign out_write_misses    = wr_mis_r;
  assign out_dirty_evictions = dev_r;

  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request taken while result pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready && !out_valid)
    else $error("block not busy after request");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted_valid && !out_evicted_dirty)
    else $error("lookup hit reports an eviction");

  a_dirty_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted_dirty |-> out_evicted_valid)
    else $error("dirty eviction without valid line");

endmodule
`default_nettype wire

// ----- tb/sv/set_assoc_cache_tag_store_tb.sv -----
// ----------------------------------------------------------------------------
// Cache tag store testbench
// Sends lookup and install requests through the valid/ready channel over
// several set-count and replacement settings. A built-in tag store predictor
// computes each result, and the result channel is checked field by field.
// Both sides idle at random, and the receiver holds off once for a long time.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_store_tb;

  localparam int NWAY = 8;
  localparam int NLINE = 2048;
  localparam int MAX_LOG2 = 8;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic        op;
    logic [31:0] addr;
    logic        wr;
    logic [63:0] stamp;
  } access_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  way;
    logic        ev_valid;
    logic        ev_dirty;
    logic [31:0] ev_tag;
    logic [31:0] rd_acc;
    logic [31:0] wr_acc;
    logic [31:0] rd_miss;
    logic [31:0] wr_miss;
    logic [31:0] dirty_ev;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = sacts_pkg::CFG_SET_LOG2;
  logic [sacts_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = sacts_pkg::OP_LOOKUP;
  logic [31:0] in_line_addr = '0;
  logic in_is_write = 1'b0;
  logic [63:0] in_now_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic [2:0] out_victim_way;
  logic out_evicted_valid;
  logic out_evicted_dirty;
  logic [31:0] out_evicted_tag;
  logic [31:0] out_read_accesses;
  logic [31:0] out_write_accesses;
  logic [31:0] out_read_misses;
  logic [31:0] out_write_misses;
  logic [31:0] out_dirty_evictions;

  set_assoc_cache_tag_store uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_line_addr(in_line_addr), .in_is_write(in_is_write),
    .in_now_time(in_now_time),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
    .out_victim_way(out_victim_way), .out_evicted_valid(out_evicted_valid),
    .out_evicted_dirty(out_evicted_dirty), .out_evicted_tag(out_evicted_tag),
    .out_read_accesses(out_read_accesses), .out_write_accesses(out_write_accesses),
    .out_read_misses(out_read_misses), .out_write_misses(out_write_misses),
    .out_dirty_evictions(out_dirty_evictions)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // tag store shadow
  logic        ts_valid [NLINE];
  logic        ts_dirty [NLINE];
  logic [31:0] ts_tag [NLINE];
  logic [63:0] ts_stamp [NLINE];
  logic [31:0] n_rd_acc, n_wr_acc, n_rd_miss, n_wr_miss, n_dirty_ev;
  logic [15:0] shadow_lfsr;
  logic [3:0]  set_log2;
  logic        policy;

  access_t  pending_reqs[$];
  outcome_t expected_outcomes[$];
  int errors = 0;
  int cyc = 0;
  int accepted = 0;
  int stall_cycles = 0;
  bit hold_done = 0;
  int hold_left = 0;
  logic [63:0] clock_stamp = 64'd1;

  function automatic logic [31:0] bump(input logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function automatic outcome_t predict_access(input access_t a);
    outcome_t r;
    int k, base, w, pick;
    logic [31:0] tag;
    logic [63:0] oldest;
    r = '0;
    k = (set_log2 > MAX_LOG2) ? MAX_LOG2 : set_log2;
    base = int'(a.addr & ((32'd1 << k) - 32'd1)) * NWAY;
    tag = a.addr >> k;
    if (a.op == sacts_pkg::OP_LOOKUP) begin
      if (a.wr) n_wr_acc = bump(n_wr_acc);
      else n_rd_acc = bump(n_rd_acc);
      for (w = 0; w < NWAY; w++) begin
        if (!r.hit && ts_valid[base+w] && ts_tag[base+w] == tag) begin
          r.hit = 1'b1;
          r.way = w[2:0];
          if (a.wr) ts_dirty[base+w] = 1'b1;
          ts_stamp[base+w] = a.stamp;
        end
      end
      if (!r.hit) begin
        if (a.wr) n_wr_miss = bump(n_wr_miss);
        else n_rd_miss = bump(n_rd_miss);
      end
    end else begin
      pick = -1;
      for (w = NWAY - 1; w >= 0; w--)
        if (!ts_valid[base+w]) pick = w;
      if (pick < 0) begin
        if (policy == sacts_pkg::POLICY_LRU) begin
          pick = 0;
          oldest = ts_stamp[base];
          for (w = 0; w < NWAY; w++) begin
            if (ts_stamp[base+w] <= oldest) begin
              pick = w;
              oldest = ts_stamp[base+w];
            end
          end
        end else begin
          shadow_lfsr = {shadow_lfsr[0] ^ shadow_lfsr[2] ^ shadow_lfsr[3] ^ shadow_lfsr[5],
                         shadow_lfsr[15:1]};
          pick = int'(shadow_lfsr % NWAY);
        end
      end
      r.way = pick[2:0];
      if (ts_valid[base+pick]) begin
        r.ev_valid = 1'b1;
        r.ev_dirty = ts_dirty[base+pick];
        r.ev_tag = ts_tag[base+pick];
      end
      if (r.ev_dirty) n_dirty_ev = bump(n_dirty_ev);
      ts_valid[base+pick] = 1'b1;
      ts_dirty[base+pick] = a.wr;
      ts_tag[base+pick] = tag;
      ts_stamp[base+pick] = a.stamp;
    end
    r.rd_acc = n_rd_acc;
    r.wr_acc = n_wr_acc;
    r.rd_miss = n_rd_miss;
    r.wr_miss = n_wr_miss;
    r.dirty_ev = n_dirty_ev;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function automatic bit quiet_window();
    return (cyc % 5000) >= 3500;
  endfunction

  // driver
  always @(posedge clk) begin
    access_t nxt;
    cyc <= cyc + 1;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_outcomes.push_back(predict_access({in_op, in_line_addr, in_is_write,
                                                    in_now_time}));
        accepted <= accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && (quiet_window() || $urandom_range(99) >= 14)) begin
          nxt = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_op <= nxt.op;
          in_line_addr <= nxt.addr;
          in_is_write <= nxt.wr;
          in_now_time <= nxt.stamp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && accepted >= 300) begin
      hold_done <= 1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_window() || $urandom_range(99) >= 14;
    end
  end

  // monitor
  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_outcomes.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = expected_outcomes.pop_front();
        check_field("hit", 64'(e.hit), 64'(out_hit));
        check_field("victim_way", 64'(e.way), 64'(out_victim_way));
        check_field("evicted_valid", 64'(e.ev_valid), 64'(out_evicted_valid));
        check_field("evicted_dirty", 64'(e.ev_dirty), 64'(out_evicted_dirty));
        check_field("evicted_tag", 64'(e.ev_tag), 64'(out_evicted_tag));
        check_field("read_accesses", 64'(e.rd_acc), 64'(out_read_accesses));
        check_field("write_accesses", 64'(e.wr_acc), 64'(out_write_accesses));
        check_field("read_misses", 64'(e.rd_miss), 64'(out_read_misses));
        check_field("write_misses", 64'(e.wr_miss), 64'(out_write_misses));
        check_field("dirty_evictions", 64'(e.dirty_ev), 64'(out_dirty_evictions));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_req(input logic op, input logic [31:0] addr, input logic wr,
                           input logic [63:0] stamp);
    pending_reqs.push_back({op, addr, wr, stamp});
  endtask

  task automatic next_stamp(output logic [63:0] s);
    if ($urandom_range(19) == 0) begin
      s = {$urandom, $urandom};
    end else begin
      clock_stamp = clock_stamp + 64'($urandom_range(3));
      s = clock_stamp;
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_outcomes.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [sacts_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == sacts_pkg::CFG_SET_LOG2) set_log2 = val;
    else policy = val[0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [31:0] pool [24];
    logic [63:0] s;
    logic [31:0] a;
    logic [3:0]  log2_list [6];
    logic        pol_list [6];
    int i, p;
    for (i = 0; i < NLINE; i++) begin
      ts_valid[i] = 1'b0;
      ts_dirty[i] = 1'b0;
      ts_tag[i] = '0;
      ts_stamp[i] = '0;
    end
    {n_rd_acc, n_wr_acc, n_rd_miss, n_wr_miss, n_dirty_ev} = '0;
    shadow_lfsr = sacts_pkg::LFSR_SEED;
    set_log2 = sacts_pkg::SET_LOG2_RST;
    policy = sacts_pkg::POLICY_LRU;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_req(sacts_pkg::OP_LOOKUP, 32'h0, 1'b0, 64'h0);
    queue_req(sacts_pkg::OP_INSTALL, 32'h0, 1'b1, 64'h0);
    queue_req(sacts_pkg::OP_LOOKUP, 32'h0, 1'b1, 64'h5);
    queue_req(sacts_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_req(sacts_pkg::OP_INSTALL, 32'hFFFF_FFFF, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_req(sacts_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 1'b1, 64'h7);
    for (i = 1; i <= 9; i++)
      queue_req(sacts_pkg::OP_INSTALL, 32'(i) << 8, i[0], 64'(10 + i));
    queue_req(sacts_pkg::OP_INSTALL, 32'h0000_0300, 1'b0, 64'h30);
    queue_req(sacts_pkg::OP_LOOKUP, 32'h0000_0300, 1'b0, 64'h31);
    queue_req(sacts_pkg::OP_LOOKUP, 32'h0000_0100, 1'b1, 64'h32);
    queue_req(sacts_pkg::OP_INSTALL, 32'h0000_0A00, 1'b1, 64'h33);
    queue_req(sacts_pkg::OP_LOOKUP, 32'h0000_0B00, 1'b0, 64'h34);
    drain();

    log2_list = '{4'd0, 4'd3, 4'd15, 4'd8, 4'd1, 4'd5};
    pol_list = '{sacts_pkg::POLICY_RAND, sacts_pkg::POLICY_LRU, sacts_pkg::POLICY_RAND,
                 sacts_pkg::POLICY_RAND, sacts_pkg::POLICY_LRU, sacts_pkg::POLICY_RAND};
    for (p = 0; p < 6; p++) begin
      write_cfg(sacts_pkg::CFG_SET_LOG2, log2_list[p]);
      write_cfg(sacts_pkg::CFG_POLICY, sacts_pkg::CFG_W'(pol_list[p]));
      for (i = 0; i < 24; i++)
        pool[i] = ($urandom & 32'hFFFF_FFFC) | 32'($urandom_range(3));
      for (i = 0; i < 65; i++) begin
        next_stamp(s);
        if ($urandom_range(9) < 2) begin
          a = $urandom;
          queue_req(logic'($urandom_range(1)), a, logic'($urandom_range(1)), s);
        end else begin
          a = pool[$urandom_range(23)];
          queue_req(sacts_pkg::OP_LOOKUP, a, logic'($urandom_range(1)), s);
          if ($urandom_range(9) < 6) begin
            next_stamp(s);
            queue_req(sacts_pkg::OP_INSTALL, a, logic'($urandom_range(1)), s);
          end
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
